>>> hw/rtl/vse_pkg.sv
package vse_pkg;

  localparam int MagW   = 20;
  localparam int NumDig = 6;
  localparam int CntW   = 3;
  localparam int NumVal = 5;
  localparam int FldW   = 3;

  localparam logic [MagW-1:0] Recip      = 20'd838861;
  localparam int              RecipShift = 23;

  typedef struct packed {
    logic load;
    logic step;
    logic pop;
  } conv_ctl_t;

  typedef struct packed {
    logic       more;
    logic       dig_more;
    logic [3:0] digit;
  } conv_sts_t;

endpackage

>>> hw/rtl/vse_conv.sv
module vse_conv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vse_pkg::conv_ctl_t        ctl,
  input  logic [vse_pkg::MagW-1:0]  mag_in,
  output vse_pkg::conv_sts_t        sts
);
  import vse_pkg::*;

  logic [MagW-1:0]   mag_r;
  logic [CntW-1:0]   cnt_r;
  logic [3:0]        dig_r [NumDig];
  logic [2*MagW-1:0] prod;
  logic [MagW-1:0]   quo;
  logic [MagW-1:0]   rem;
  logic [CntW-1:0]   rd_idx;

  assign prod   = mag_r * Recip;
  assign quo    = MagW'(prod[2*MagW-1:RecipShift]);
  assign rem    = mag_r - ({quo[MagW-4:0], 3'b000} + {quo[MagW-2:0], 1'b0});
  assign rd_idx = cnt_r - CntW'(1);

  assign sts.more     = (quo != '0) && (cnt_r != CntW'(NumDig - 1));
  assign sts.dig_more = (cnt_r != CntW'(1));
  assign sts.digit    = dig_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.load) begin
      cnt_r <= '0;
    end else if (ctl.step) begin
      cnt_r <= cnt_r + CntW'(1);
    end else if (ctl.pop) begin
      cnt_r <= cnt_r - CntW'(1);
    end
    if (ctl.load) begin
      mag_r <= mag_in;
    end else if (ctl.step) begin
      mag_r <= quo;
      dig_r[cnt_r] <= rem[3:0];
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(NumDig)) else $error("digit count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> cnt_r != '0) else $error("digit pop while empty");
  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> cnt_r < CntW'(NumDig)) else $error("digit store overflow");

endmodule

>>> hw/rtl/vario_sentence_encoder.sv
// channel | dir | tdata fields (low bit up)                          | tuser | tlast
// in_     | in  | pressure 20, altitude 18, climb_cms 15,              | -     | -
//         |     | temperature_deci 11, battery 17, zero pad 7          |       |
// out_    | out | out_byte 8                                           | -     | last_byte
// One record gives a 22 to 43 byte sentence (drop the line feed past 43), one byte per cycle
// at most while out_tready is high: the microcode steps once per cycle
// unless an emit step is stalled, and runs the divide-by-ten unit once per decimal digit
// before emitting the digits. in_tready is high only in the idle step.
// Reset: synchronous, active low; clears the step counter and output valid.
// A stall on out_tready holds the sequencer at its current emit step.
module vario_sentence_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // pressure, altitude, climb_cms, temperature_deci, battery
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast   // last_byte
);
  import vse_pkg::*;

  typedef enum logic [1:0] {B_LIT, B_DIGIT, B_HEX_HI, B_HEX_LO} bsel_t;
  typedef enum logic [2:0] {OP_NONE, OP_LOAD_FIELD, OP_CONVERT, OP_POP, OP_FIELD_INC} op_t;
  typedef enum logic [2:0] {C_NEVER, C_ALWAYS, C_WAIT, C_POS, C_CONV, C_DIG, C_FIELD} cond_t;

  localparam int PcW = 5;

  typedef struct packed {
    logic           emit;
    logic           sum;
    logic           last;
    bsel_t          bsel;
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;
    logic [7:0]     lit;
  } ctrl_t;

  localparam logic [PcW-1:0] StIdle  = 5'd0;
  localparam logic [PcW-1:0] StComma = 5'd8;
  localparam logic [PcW-1:0] StConv  = 5'd10;
  localparam logic [PcW-1:0] StDigit = 5'd11;
  localparam logic [FldW-1:0] LastField = FldW'(NumVal - 1);
  localparam logic [5:0]     MaxOut  = 6'd43;

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '{emit: 1'b0, sum: 1'b0, last: 1'b0, bsel: B_LIT, op: OP_NONE,
          cond: C_NEVER, target: StIdle, lit: 8'h00};
    case (pc)
      5'd0:  begin c.cond = C_WAIT; c.target = StIdle; end
      5'd1:  begin c.emit = 1'b1; c.lit = 8'h24; end
      5'd2:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h4C; end
      5'd3:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h4B; end
      5'd4:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h38; end
      5'd5:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h45; end
      5'd6:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h58; end
      5'd7:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h31; end
      5'd8:  begin
        c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h2C; c.op = OP_LOAD_FIELD;
        c.cond = C_POS; c.target = StConv;
      end
      5'd9:  begin c.emit = 1'b1; c.sum = 1'b1; c.lit = 8'h2D; end
      5'd10: begin c.op = OP_CONVERT; c.cond = C_CONV; c.target = StConv; end
      5'd11: begin
        c.emit = 1'b1; c.sum = 1'b1; c.bsel = B_DIGIT; c.op = OP_POP;
        c.cond = C_DIG; c.target = StDigit;
      end
      5'd12: begin c.op = OP_FIELD_INC; c.cond = C_FIELD; c.target = StComma; end
      5'd13: begin c.emit = 1'b1; c.lit = 8'h2A; end
      5'd14: begin c.emit = 1'b1; c.bsel = B_HEX_HI; end
      5'd15: begin c.emit = 1'b1; c.bsel = B_HEX_LO; end
      5'd16: begin c.emit = 1'b1; c.lit = 8'h0D; end
      5'd17: begin
        c.emit = 1'b1; c.last = 1'b1; c.lit = 8'h0A; c.cond = C_ALWAYS;
        c.target = StIdle;
      end
      default: begin c.cond = C_ALWAYS; c.target = StIdle; end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  logic [PcW-1:0]  pc_r, pc_nxt;
  logic [FldW-1:0] field_r;
  logic [7:0]      xor_r;
  logic [5:0]      pos_r;
  logic [MagW-1:0] held_r [NumVal];
  logic            out_tvalid_r;
  logic [7:0]      out_tdata_r;
  logic            out_tlast_r;

  ctrl_t           cw;
  conv_ctl_t       conv_ctl;
  conv_sts_t       conv_sts;
  logic            in_fire, out_free, fire, jump, emit_en;
  logic [7:0]      byte_val;
  logic [MagW-1:0] sel, mag;
  logic [MagW-1:0] sat [NumVal];

  logic [19:0]        raw_p;
  logic signed [17:0] raw_a;
  logic signed [14:0] raw_c;
  logic signed [10:0] raw_t;
  logic [16:0]        raw_b;
  logic [19:0]        sat_p;
  logic signed [17:0] sat_a;
  logic signed [14:0] sat_c;
  logic signed [10:0] sat_t;
  logic [16:0]        sat_b;

  assign cw         = ucode(pc_r);
  assign in_tready  = (pc_r == StIdle);
  assign in_fire    = in_tvalid && in_tready;
  assign emit_en    = cw.emit && (pos_r < MaxOut);
  assign out_free   = !out_tvalid_r || out_tready;
  assign fire       = !emit_en || out_free;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign raw_p = in_tdata[19:0];
  assign raw_a = in_tdata[37:20];
  assign raw_c = in_tdata[52:38];
  assign raw_t = in_tdata[63:53];
  assign raw_b = in_tdata[80:64];

  always_comb begin
    sat_p = (raw_p > 20'd999999) ? 20'd999999 : raw_p;
    sat_a = (raw_a > 18'sd99999) ? 18'sd99999 :
            (raw_a < -18'sd99999) ? -18'sd99999 : raw_a;
    sat_c = (raw_c > 15'sd9999) ? 15'sd9999 :
            (raw_c < -15'sd9999) ? -15'sd9999 : raw_c;
    sat_t = (raw_t > 11'sd999) ? 11'sd999 :
            (raw_t < -11'sd999) ? -11'sd999 : raw_t;
    sat_b = (raw_b > 17'd99999) ? 17'd99999 : raw_b;
    sat[0] = sat_p;
    sat[1] = {{2{sat_a[17]}}, sat_a};
    sat[2] = {{5{sat_c[14]}}, sat_c};
    sat[3] = {{9{sat_t[10]}}, sat_t};
    sat[4] = {3'b000, sat_b};
  end

  always_comb begin
    case (field_r)
      3'd0:    sel = held_r[0];
      3'd1:    sel = held_r[1];
      3'd2:    sel = held_r[2];
      3'd3:    sel = held_r[3];
      3'd4:    sel = held_r[4];
      default: sel = '0;
    endcase
    mag = sel[MagW-1] ? (~sel + MagW'(1)) : sel;
  end

  assign conv_ctl.load = fire && (cw.op == OP_LOAD_FIELD);
  assign conv_ctl.step = fire && (cw.op == OP_CONVERT);
  assign conv_ctl.pop  = fire && (cw.op == OP_POP);

  vse_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (conv_ctl),
    .mag_in (mag),
    .sts    (conv_sts)
  );

  always_comb begin
    case (cw.bsel)
      B_LIT:    byte_val = cw.lit;
      B_DIGIT:  byte_val = {4'h3, conv_sts.digit};
      B_HEX_HI: byte_val = hex_char(xor_r[7:4]);
      B_HEX_LO: byte_val = hex_char(xor_r[3:0]);
      default:  byte_val = cw.lit;
    endcase
  end

  always_comb begin
    case (cw.cond)
      C_NEVER:  jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_WAIT:   jump = !in_tvalid;
      C_POS:    jump = !sel[MagW-1];
      C_CONV:   jump = conv_sts.more;
      C_DIG:    jump = conv_sts.dig_more;
      C_FIELD:  jump = (field_r != LastField);
      default:  jump = 1'b0;
    endcase
    if (!fire) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + PcW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= StIdle;
      field_r      <= '0;
      xor_r        <= '0;
      pos_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (in_fire) begin
        field_r <= '0;
        xor_r   <= '0;
      end else if (fire && cw.op == OP_FIELD_INC) begin
        field_r <= field_r + FldW'(1);
      end
      if (fire && cw.emit && cw.sum) begin
        xor_r <= xor_r ^ byte_val;
      end
      if (in_fire) begin
        pos_r <= '0;
      end else if (fire && emit_en) begin
        pos_r <= pos_r + 6'd1;
      end
      if (fire && emit_en) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      for (int i = 0; i < NumVal; i++) begin
        held_r[i] <= sat[i];
      end
    end
    if (fire && emit_en) begin
      out_tdata_r <= byte_val;
      out_tlast_r <= cw.last;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pc_r == 5'd1 && xor_r == '0 && field_r == '0)
    else $error("record start not taken");
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == StComma |-> field_r <= LastField)
    else $error("field index past last value");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en && out_tvalid_r && !out_tready |=> $stable(pc_r))
    else $error("sequencer advanced during output stall");

endmodule
